// File: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NACK  = 2'd1,
        ST_BUSY  = 2'd2,
        ST_ERROR = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_0 = 4'd0,
        PH_1 = 4'd1,
        PH_2 = 4'd2,
        PH_3 = 4'd3,
        PH_4 = 4'd4,
        PH_5 = 4'd5,
        PH_6 = 4'd6
    } t_step;

    typedef struct packed {
        t_op        op;
        logic [7:0] wdata;
        logic       ack;
        logic       sda;
    } t_tick;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam int         QDEPTH        = 2;
    localparam int         QPTR_W        = 1;
    localparam int         QCNT_W        = 2;

endpackage

// File: sv/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_in_if / i2cm_out_if
// Valid/ready channels for phase tick items and result items.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] write_data;
    logic       ack_after_read;
    logic       sda_in;

    modport source (output valid, command, write_data, ack_after_read, sda_in,
                    input ready);
    modport sink   (input valid, command, write_data, ack_after_read, sda_in,
                    output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [1:0] status;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data, status,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data, status,
                     output ready);
endinterface

// File: sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick items and decodes the command field into an operation.
// ----------------------------------------------------------------------------
module i2cm_front (
    i2cm_in_if.sink         i_in,
    input  i2cm_pkg::t_qstat i_qstat,
    output logic            o_push,
    output i2cm_pkg::t_tick o_item
);
    import i2cm_pkg::*;

    t_op op;

    always_comb begin
        unique case (i_in.command) inside
            OP_START, OP_STOP, OP_WRITE, OP_READ: op = t_op'(i_in.command);
            default:                              op = OP_IDLE;
        endcase
    end

    assign i_in.ready   = !i_qstat.full;
    assign o_push       = i_in.valid && !i_qstat.full;
    assign o_item.op    = op;
    assign o_item.wdata = i_in.write_data;
    assign o_item.ack   = i_in.ack_after_read;
    assign o_item.sda   = i_in.sda_in;

endmodule

// File: sv/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry item queue between the front and the engine.
// ----------------------------------------------------------------------------
module i2cm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2cm_pkg::t_tick  i_item,
    input  logic             i_pop,
    output i2cm_pkg::t_tick  o_item,
    output i2cm_pkg::t_qstat o_qstat
);
    import i2cm_pkg::*;

    t_tick              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

    assign o_item        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// File: sv/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bit sequencer: steps SCL/SDA levels per tick and registers the result.
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  i2cm_pkg::t_qstat i_qstat,
    input  i2cm_pkg::t_tick  i_item,
    output logic             o_pop,
    i2cm_out_if.source       o_out
);
    import i2cm_pkg::*;

    t_op        r_op,     n_op;
    t_step      r_step,   n_step;
    logic [3:0] r_cnt,    n_cnt;
    logic [7:0] r_shift,  n_shift;
    logic       r_scl,    n_scl;
    logic       r_sda,    n_sda;
    t_status    r_status, n_status;
    logic       r_ack,    n_ack;
    logic [7:0] r_rbyte,  n_rbyte;
    logic       n_done;
    logic [3:0] cnt_inc;
    logic       r_valid;
    logic       r_o_scl, r_o_sda, r_o_busy, r_o_done;
    logic [7:0] r_o_rdata;
    logic [1:0] r_o_status;

    assign o_pop   = !i_qstat.empty && (!r_valid || o_out.ready);
    assign cnt_inc = r_cnt + 4'd1;

    // next state
    always_comb begin
        n_op   = r_op;
        n_step = r_step;
        n_done = 1'b0;
        unique case (r_op)
            OP_IDLE: begin
                if (i_item.op != OP_IDLE) begin
                    n_op   = i_item.op;
                    n_step = PH_1;
                end
            end
            OP_START: begin
                case (r_step)
                    PH_1: n_step = PH_2;
                    PH_2: begin
                        if (!i_item.sda) begin
                            n_op = OP_IDLE; n_step = PH_0; n_done = 1'b1;
                        end else begin
                            n_step = PH_3;
                        end
                    end
                    PH_3:    n_step = PH_4;
                    default: begin
                        n_op = OP_IDLE; n_step = PH_0; n_done = 1'b1;
                    end
                endcase
            end
            OP_STOP: begin
                case (r_step)
                    PH_1:    n_step = PH_2;
                    default: begin
                        n_op = OP_IDLE; n_step = PH_0; n_done = 1'b1;
                    end
                endcase
            end
            OP_WRITE: begin
                case (r_step)
                    PH_1: n_step = PH_2;
                    PH_2: n_step = PH_3;
                    PH_3: n_step = (cnt_inc >= BITS_PER_BYTE) ? PH_4 : PH_1;
                    PH_4: n_step = PH_5;
                    PH_5: n_step = PH_6;
                    default: begin
                        n_op = OP_IDLE; n_step = PH_0; n_done = 1'b1;
                    end
                endcase
            end
            OP_READ: begin
                case (r_step)
                    PH_1: n_step = PH_2;
                    PH_2: n_step = (cnt_inc >= BITS_PER_BYTE) ? PH_3 : PH_1;
                    PH_3: n_step = PH_4;
                    PH_4: n_step = PH_5;
                    PH_5: n_step = PH_6;
                    default: begin
                        n_op = OP_IDLE; n_step = PH_0; n_done = 1'b1;
                    end
                endcase
            end
            default: begin
                n_op   = OP_IDLE;
                n_step = PH_0;
            end
        endcase
    end

    // pin levels and datapath
    always_comb begin
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_status = r_status;
        n_ack    = r_ack;
        n_rbyte  = r_rbyte;
        unique case (r_op)
            OP_IDLE: begin
                case (i_item.op)
                    OP_START: n_sda = 1'b1;
                    OP_STOP:  n_sda = 1'b0;
                    OP_WRITE: begin
                        n_scl = 1'b0; n_shift = i_item.wdata; n_cnt = '0;
                    end
                    OP_READ: begin
                        n_sda = 1'b1; n_scl = 1'b0; n_shift = '0; n_cnt = '0;
                        n_ack = i_item.ack;
                    end
                    default: ;
                endcase
            end
            OP_START: begin
                case (r_step)
                    PH_1: n_scl = 1'b1;
                    PH_2: begin
                        if (!i_item.sda) n_status = ST_BUSY;
                        else             n_sda    = 1'b0;
                    end
                    PH_3:    n_scl    = 1'b0;
                    default: n_status = i_item.sda ? ST_ERROR : ST_OK;
                endcase
            end
            OP_STOP: begin
                case (r_step)
                    PH_1: n_scl = 1'b1;
                    default: begin
                        n_sda = 1'b1; n_status = ST_OK;
                    end
                endcase
            end
            OP_WRITE: begin
                case (r_step)
                    PH_1: n_sda = r_shift[7];
                    PH_2: n_scl = 1'b1;
                    PH_3: begin
                        n_scl = 1'b0; n_shift = {r_shift[6:0], 1'b0}; n_cnt = cnt_inc;
                    end
                    PH_4: n_sda = 1'b1;
                    PH_5: n_scl = 1'b1;
                    default: begin
                        n_scl = 1'b0; n_sda = 1'b1;
                        n_status = i_item.sda ? ST_NACK : ST_OK;
                    end
                endcase
            end
            OP_READ: begin
                case (r_step)
                    PH_1: n_scl = 1'b1;
                    PH_2: begin
                        n_shift = {r_shift[6:0], i_item.sda}; n_scl = 1'b0; n_cnt = cnt_inc;
                    end
                    PH_3: n_sda = r_ack;
                    PH_4: n_scl = 1'b1;
                    PH_5: n_scl = 1'b0;
                    default: begin
                        n_sda = 1'b1; n_rbyte = r_shift; n_status = ST_OK;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_IDLE;
            r_step   <= PH_0;
            r_cnt    <= '0;
            r_shift  <= '0;
            r_scl    <= 1'b0;
            r_sda    <= 1'b1;
            r_status <= ST_OK;
            r_ack    <= 1'b1;
            r_rbyte  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_op     <= n_op;
                r_step   <= n_step;
                r_cnt    <= n_cnt;
                r_shift  <= n_shift;
                r_scl    <= n_scl;
                r_sda    <= n_sda;
                r_status <= n_status;
                r_ack    <= n_ack;
                r_rbyte  <= n_rbyte;
                r_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_scl    <= n_scl;
            r_o_sda    <= n_sda;
            r_o_busy   <= (n_op != OP_IDLE);
            r_o_done   <= n_done;
            r_o_rdata  <= n_rbyte;
            r_o_status <= n_status;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.scl_out   = r_o_scl;
    assign o_out.sda_out   = r_o_sda;
    assign o_out.busy_res  = r_o_busy;
    assign o_out.done_res  = r_o_done;
    assign o_out.read_data = r_o_rdata;
    assign o_out.status    = r_o_status;

endmodule

// File: sv/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bit engine: one phase tick item in, one result item out.
// ----------------------------------------------------------------------------
// Takes one tick item per clock and returns one result item per tick, in
// order, while results are being taken. A tick passes a two-entry queue and
// the bit sequencer, whose output register holds the result: an item
// accepted into an empty queue is written to the queue, then popped into the
// sequencer, which registers its result. The sequencer's state update sets
// the rate of one item per clock; input ready drops only when the queue is
// full because results are not being taken.
module i2c_master_byte_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cm_in_if.sink    i_in,
    i2cm_out_if.source o_out
);
    import i2cm_pkg::*;

    t_qstat qstat;
    t_tick  push_item;
    t_tick  pop_item;
    logic   push;
    logic   pop;

    i2cm_front u_front (
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_item  (push_item)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_qstat (qstat)
    );

    i2cm_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_item  (pop_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && qstat.empty))
        else $error("pop from empty queue");

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_out.valid)
        else $error("popped item produced no result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.done_res) |-> !o_out.busy_res)
        else $error("done and busy in one result");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.full |-> !push)
        else $error("push into full queue");

endmodule
